// ----- design/dsa_pkg.sv -----
// package for the double-ended scratch allocator
// command and status codes, alignment constant, marker control struct
// no dependencies
`default_nettype none

package dsa_pkg;

    localparam int MARKER_DEPTH_DEF = 16;
    localparam int SIZE_BITS_DEF    = 20;
    localparam int ALIGN_BYTES      = 8;
    localparam int RESET_BYTES      = 65536;

    localparam int CMD_W  = 3;
    localparam int STAT_W = 3;

    localparam logic [CMD_W-1:0] CMD_STACK_ALLOC  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_MARKER  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_MARKER   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_BUFFER_ALLOC = 3'd3;
    localparam logic [CMD_W-1:0] CMD_TOGGLE       = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
    localparam logic [STAT_W-1:0] ST_ZERO    = 3'd1;
    localparam logic [STAT_W-1:0] ST_OOM     = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL    = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOMARK  = 3'd4;
    localparam logic [STAT_W-1:0] ST_DISCARD = 3'd5;

    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } t_mark_ctl;

endpackage

`default_nettype wire

// ----- design/dsa_marker_stack.sv -----
// marker stack: saved stack tops in a small memory with a cached top entry
// depends on dsa_pkg
`default_nettype none

module dsa_marker_stack
    import dsa_pkg::*;
#(
    parameter int MARKER_DEPTH = MARKER_DEPTH_DEF,
    parameter int VAL_W        = SIZE_BITS_DEF + 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_mark_ctl        i_ctl,
    input  wire logic [VAL_W-1:0] i_wdata,
    output logic      [VAL_W-1:0] o_top,
    output logic                  o_empty,
    output logic                  o_full
);

    localparam int IDX_W = (MARKER_DEPTH > 1) ? $clog2(MARKER_DEPTH) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MARKER_DEPTH - 1);

    logic [VAL_W-1:0] r_mem [MARKER_DEPTH];
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] n_idx;
    logic [VAL_W-1:0] r_top;
    logic [VAL_W-1:0] n_top;
    logic [VAL_W-1:0] r_rdata;
    logic [IDX_W-1:0] rd_addr;

    always_comb begin
        n_idx = r_idx;
        n_top = r_top;
        priority if (i_ctl.clear) begin
            n_idx = '0;
        end else if (i_ctl.push) begin
            n_idx = r_idx + IDX_W'(1);
            n_top = i_wdata;
        end else if (i_ctl.pop) begin
            n_idx = r_idx - IDX_W'(1);
            n_top = r_rdata;
        end else begin
            // hold
        end
    end

    // prefetch the entry below the new top
    assign rd_addr = (n_idx == '0) ? '0 : n_idx - IDX_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else begin
            r_idx <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top <= n_top;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push && !i_ctl.clear) begin
            r_mem[n_idx] <= i_wdata;
        end
        r_rdata <= r_mem[rd_addr];
    end

    assign o_top   = r_top;
    assign o_empty = (r_idx == '0);
    assign o_full  = (r_idx == IDX_LAST);

endmodule

`default_nettype wire

// ----- design/double_ended_scratch_allocator_core.sv -----
// top level of the double-ended scratch allocator
// depends on dsa_pkg and dsa_marker_stack
//
// usage:
//   command channel: i_cmd and i_nbytes are taken at a rising edge with
//   i_start high and o_busy low. o_busy is always low, so one item can be
//   issued every cycle.
//   result channel: o_done is high for exactly one cycle with o_status,
//   o_address, o_section, o_stack_used, o_buffer_used and o_free_bytes.
//   the receiver cannot stall; results must be taken when o_done is high.
//   pipeline: the accepting edge loads the input register, and the result
//   register then takes the result.
//   throughput: one item per cycle; the stack top, buffer point and marker
//   stack are updated between the two registers.
//   configuration: i_cfg_we writes i_cfg_wdata as the section size, clamped
//   to 2^SIZE_BITS and rounded up to the alignment; it is adopted at the
//   next toggle command.
//   reset: synchronous active-low i_rst_n empties both ends, selects
//   section 0, sets the section size to its reset value and drops any
//   item in flight.
`default_nettype none

module double_ended_scratch_allocator_core
    import dsa_pkg::*;
#(
    parameter int MARKER_DEPTH = MARKER_DEPTH_DEF,
    parameter int SIZE_BITS    = SIZE_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    output logic                      o_busy,
    input  wire logic [CMD_W-1:0]     i_cmd,
    input  wire logic [SIZE_BITS-1:0] i_nbytes,
    input  wire logic                 i_cfg_we,
    input  wire logic [SIZE_BITS:0]   i_cfg_wdata,
    output logic                      o_done,
    output logic [STAT_W-1:0]         o_status,
    output logic [SIZE_BITS:0]        o_address,
    output logic                      o_section,
    output logic [SIZE_BITS:0]        o_stack_used,
    output logic [SIZE_BITS:0]        o_buffer_used,
    output logic [SIZE_BITS:0]        o_free_bytes
);

    localparam int VAL_W = SIZE_BITS + 1;
    localparam logic [VAL_W-1:0] SIZE_LIMIT  = {1'b1, {SIZE_BITS{1'b0}}};
    localparam logic [VAL_W-1:0] ALIGN_ADD   = VAL_W'(ALIGN_BYTES - 1);
    localparam logic [VAL_W-1:0] ALIGN_MASK  = ~ALIGN_ADD;
    localparam logic [VAL_W-1:0] RESET_SIZE  =
        (SIZE_BITS >= 16) ? VAL_W'(RESET_BYTES) : SIZE_LIMIT;

    // input register
    logic                 r_vld;
    logic [CMD_W-1:0]     r_cmd;
    logic [SIZE_BITS-1:0] r_nbytes;

    // allocator state
    logic [VAL_W-1:0] r_region;
    logic [VAL_W-1:0] n_region;
    logic [VAL_W-1:0] r_act_size;
    logic [VAL_W-1:0] n_act_size;
    logic [VAL_W-1:0] r_stack_top;
    logic [VAL_W-1:0] n_stack_top;
    logic [VAL_W-1:0] r_buf_pt;
    logic [VAL_W-1:0] n_buf_pt;
    logic             r_section;
    logic             n_section;

    // result register
    logic              r_done;
    logic [STAT_W-1:0] r_status;
    logic [STAT_W-1:0] n_status;
    logic [VAL_W-1:0]  r_address;
    logic [VAL_W-1:0]  n_address;
    logic [VAL_W-1:0]  r_stack_used;
    logic [VAL_W-1:0]  r_buffer_used;
    logic [VAL_W-1:0]  r_free_bytes;

    logic [VAL_W-1:0] cfg_clamped;
    logic [VAL_W-1:0] req_round;
    logic [VAL_W:0]   alloc_end;
    logic             oom;
    t_mark_ctl        mark_ctl;
    logic [VAL_W-1:0] mark_top;
    logic             mark_empty;
    logic             mark_full;

    assign o_busy = 1'b0;

    // config clamp and round up
    always_comb begin
        cfg_clamped = (i_cfg_wdata > SIZE_LIMIT) ? SIZE_LIMIT : i_cfg_wdata;
        n_region    = (cfg_clamped + ALIGN_ADD) & ALIGN_MASK;
    end

    assign req_round = ({1'b0, r_nbytes} + ALIGN_ADD) & ALIGN_MASK;
    assign alloc_end = {1'b0, r_stack_top} + {1'b0, req_round};
    assign oom       = (alloc_end >= {1'b0, r_buf_pt});

    always_comb begin
        n_stack_top    = r_stack_top;
        n_buf_pt       = r_buf_pt;
        n_act_size     = r_act_size;
        n_section      = r_section;
        n_status       = ST_OK;
        n_address      = '0;
        mark_ctl       = '0;
        if (r_vld) begin
            unique case (r_cmd)
                CMD_STACK_ALLOC: begin
                    if (r_nbytes == '0) begin
                        n_status = ST_ZERO;
                    end else if (oom) begin
                        n_status = ST_OOM;
                    end else begin
                        n_address   = r_stack_top;
                        n_stack_top = alloc_end[VAL_W-1:0];
                    end
                end
                CMD_PUSH_MARKER: begin
                    if (mark_full) begin
                        n_status = ST_FULL;
                    end else begin
                        mark_ctl.push = 1'b1;
                    end
                end
                CMD_POP_MARKER: begin
                    if (mark_empty) begin
                        n_status = ST_NOMARK;
                    end else begin
                        mark_ctl.pop = 1'b1;
                        n_stack_top  = mark_top;
                    end
                end
                CMD_BUFFER_ALLOC: begin
                    if (r_nbytes == '0) begin
                        n_status = ST_ZERO;
                    end else if (oom) begin
                        n_status = ST_OOM;
                    end else begin
                        n_buf_pt  = r_buf_pt - req_round;
                        n_address = r_buf_pt - req_round;
                    end
                end
                CMD_TOGGLE: begin
                    if (!mark_empty) begin
                        n_status = ST_DISCARD;
                    end
                    mark_ctl.clear = 1'b1;
                    n_act_size     = r_region;
                    n_section      = ~r_section;
                    n_stack_top    = '0;
                    n_buf_pt       = r_region;
                end
                default: begin
                end
            endcase
        end
    end

    dsa_marker_stack #(
        .MARKER_DEPTH(MARKER_DEPTH),
        .VAL_W       (VAL_W)
    ) u_marker (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (mark_ctl),
        .i_wdata(r_stack_top),
        .o_top  (mark_top),
        .o_empty(mark_empty),
        .o_full (mark_full)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= 1'b0;
            r_done      <= 1'b0;
            r_region    <= RESET_SIZE;
            r_act_size  <= RESET_SIZE;
            r_stack_top <= '0;
            r_buf_pt    <= RESET_SIZE;
            r_section   <= 1'b0;
        end else begin
            r_vld       <= i_start && !o_busy;
            r_done      <= r_vld;
            if (i_cfg_we) begin
                r_region <= n_region;
            end
            r_act_size  <= n_act_size;
            r_stack_top <= n_stack_top;
            r_buf_pt    <= n_buf_pt;
            r_section   <= n_section;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd         <= i_cmd;
        r_nbytes      <= i_nbytes;
        r_status      <= n_status;
        r_address     <= n_address;
        r_stack_used  <= n_stack_top;
        r_buffer_used <= n_act_size - n_buf_pt;
        r_free_bytes  <= n_buf_pt - n_stack_top;
    end

    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_address     = r_address;
    assign o_section     = r_section;
    assign o_stack_used  = r_stack_used;
    assign o_buffer_used = r_buffer_used;
    assign o_free_bytes  = r_free_bytes;

endmodule

`default_nettype wire
